### rtl/core/nls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_pkg
// shared types and constants of the neighbour link scoring block
// ----------------------------------------------------------------------------
package nls_pkg;

    localparam int unsigned LONG_CAP     = 200000;
    localparam int unsigned RECENT_CAP   = 5000;
    localparam int unsigned RECENT_AGE   = 5000;
    localparam int unsigned MAX_INTERVAL = 3600000;
    localparam int unsigned SCORE_MAX    = 255;
    localparam int unsigned GAP_RESET    = 500;
    localparam int unsigned AGE_RESET    = 20000;

    localparam int unsigned A_DIV   = LONG_CAP / 128;
    localparam int unsigned B_DIV   = RECENT_CAP / 128;
    localparam int unsigned A_MUL   = 2685;
    localparam int unsigned A_SHIFT = 22;
    localparam int unsigned B_MUL   = 1680;
    localparam int unsigned B_SHIFT = 16;

    localparam int IV_W   = 22;
    localparam int TIME_W = 63;
    localparam int LONG_W = 18;
    localparam int REC_W  = 13;

    typedef enum logic
    {
        OP_OBSERVE = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CFG_UP_MASK = 2'd0,
        CFG_MIN_GAP = 2'd1,
        CFG_MAX_AGE = 2'd2
    } cfg_index_t;

    typedef struct packed
    {
        logic [31:0]       range_start;
        logic [31:0]       range_end;
        logic [TIME_W-1:0] obs_time;
        logic [7:0]        iface;
    } obs_entry_t;

    typedef struct packed
    {
        logic [7:0]        score;
        logic [LONG_W-1:0] observed;
    } score_res_t;

endpackage

### rtl/core/nls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_if
// request, result and configuration channels
// ----------------------------------------------------------------------------
interface nls_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [6:0]  neighbour_slot;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [7:0]  heard_iface;
    logic [62:0] now_ms;

    modport source (output valid, op, neighbour_slot, range_start, range_end,
                    heard_iface, now_ms, input ready);
    modport sink (input valid, op, neighbour_slot, range_start, range_end,
                  heard_iface, now_ms, output ready);
endinterface

interface nls_out_if;
    logic        valid;
    logic        ready;
    logic        updated;
    logic [1:0]  interface_index;
    logic [7:0]  score;
    logic        score_changed;
    logic [17:0] observed_ms;
    logic        last;

    modport source (output valid, updated, interface_index, score, score_changed,
                    observed_ms, last, input ready);
    modport sink (input valid, updated, interface_index, score, score_changed,
                  observed_ms, last, output ready);
endinterface

interface nls_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/nls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nls_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/nls_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nls_score
// three stage pipeline turning window sums into a clamped link score
// ----------------------------------------------------------------------------
module nls_score
    import nls_pkg::*;
#(
    parameter int LSUM_W = 26,
    parameter int RSUM_W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [LSUM_W-1:0] lsum,
    input  logic [RSUM_W-1:0] rsum,
    output logic              done,
    output score_res_t        res
);

    logic              v1_reg, v2_reg, v3_reg;
    logic [LONG_W-1:0] l1_reg, l2_reg;
    logic [REC_W-1:0]  r1_reg;
    logic [7:0]        qa1_reg, qb1_reg, a2_reg, b2_reg;
    score_res_t        res_reg;

    logic [LONG_W-1:0] l_c;
    logic [REC_W-1:0]  r_c;
    logic [29:0]       prod_a;
    logic [23:0]       prod_b;
    logic [LONG_W-1:0] am, rem_a;
    logic [REC_W-1:0]  bm, rem_b;
    logic [8:0]        sum;
    logic [7:0]        score;

    always_comb
    begin
        l_c    = (32'(lsum) > LONG_CAP) ? LONG_W'(LONG_CAP) : LONG_W'(lsum);
        r_c    = (32'(rsum) > RECENT_CAP) ? REC_W'(RECENT_CAP) : REC_W'(rsum);
        prod_a = 30'(l_c) * 30'(A_MUL);
        prod_b = 24'(r_c) * 24'(B_MUL);
        am     = LONG_W'(qa1_reg) * LONG_W'(A_DIV);
        rem_a  = l1_reg - am;
        bm     = REC_W'(qb1_reg) * REC_W'(B_DIV);
        rem_b  = r1_reg - bm;
        sum    = (b2_reg == 8'd0) ? {2'b00, a2_reg[7:1]} : 9'(a2_reg) + 9'(b2_reg);
        if (l2_reg == '0)
        begin
            score = 8'd0;
        end
        else if (sum == 9'd0)
        begin
            score = 8'd1;
        end
        else if (32'(sum) > SCORE_MAX)
        begin
            score = 8'(SCORE_MAX);
        end
        else
        begin
            score = sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg  <= l_c;
        r1_reg  <= r_c;
        qa1_reg <= prod_a[A_SHIFT +: 8];
        qb1_reg <= prod_b[B_SHIFT +: 8];
        l2_reg  <= l1_reg;
        a2_reg  <= (32'(rem_a) >= A_DIV) ? qa1_reg + 8'd1 : qa1_reg;
        b2_reg  <= (32'(rem_b) >= B_DIV) ? qb1_reg + 8'd1 : qb1_reg;
        if (v2_reg)
        begin
            res_reg.score    <= score;
            res_reg.observed <= l2_reg;
        end
    end

    assign done = v3_reg;
    assign res  = res_reg;

endmodule

### rtl/core/neighbour_link_scoring_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_link_scoring_top
// per neighbour observation ring with merge, rate limited link scoring
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer around two memories: a
// neighbour memory (valid mask, newest ring index, last update time, stored
// scores) and an observation memory (ranges, time, interface). A tick walks
// the ring, reading, evaluating and accumulating each observation, then runs
// the scoring pass once per interface; a stall on the result side holds the
// sequencer. An observation first walks the ring back from the newest entry
// to merge and then writes one entry. A skipped update emits one result
// without scoring. Slot numbers of NEIGHBOURS or more are first reduced by
// repeated subtraction, one step a cycle. After reset the neighbour memory
// is cleared entry by entry before the first request is taken;
// configuration writes are accepted at all times.
// ----------------------------------------------------------------------------
module neighbour_link_scoring_top
    import nls_pkg::*;
#(
    parameter int OBSERVATIONS = 8,
    parameter int INTERFACES   = 4,
    parameter int NEIGHBOURS   = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    nls_cfg_if.sink      cfg,
    nls_in_if.sink       req,
    nls_out_if.source    rsp
);

    localparam int NB_W   = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam int OA_W   = $clog2(NEIGHBOURS * OBSERVATIONS);
    localparam int IDX_W  = $clog2(OBSERVATIONS);
    localparam int IF_W   = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
    localparam int SC_W   = 8 * INTERFACES;
    localparam int NBR_W  = OBSERVATIONS + IDX_W + TIME_W + SC_W;
    localparam int OBS_W  = $bits(obs_entry_t);
    localparam int LSUM_W = $clog2(MAX_INTERVAL * OBSERVATIONS);
    localparam int RSUM_W = $clog2(RECENT_CAP * OBSERVATIONS + 1);

    typedef enum logic [16:0]
    {
        S_CLR  = 17'h00001,
        S_IDLE = 17'h00002,
        S_MOD  = 17'h00004,
        S_NRD  = 17'h00008,
        S_NLD  = 17'h00010,
        S_WRD  = 17'h00020,
        S_WCK  = 17'h00040,
        S_WR   = 17'h00080,
        S_CHK  = 17'h00100,
        S_SRD  = 17'h00200,
        S_SEV  = 17'h00400,
        S_SADD = 17'h00800,
        S_SGO  = 17'h01000,
        S_SWT  = 17'h02000,
        S_EMIT = 17'h04000,
        S_SKIP = 17'h08000,
        S_WB   = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  up_mask_reg;
    logic [15:0] gap_reg;
    logic [19:0] age_reg;
    logic [NB_W-1:0] clr_cnt_reg;

    logic              op_reg;
    logic [6:0]        slot_reg;
    logic [31:0]       s1_reg, s2_reg;
    logic [7:0]        ifc_reg;
    logic [TIME_W-1:0] now_reg;

    logic [OA_W-1:0]         obs_base_reg;
    logic [OBSERVATIONS-1:0] mask_reg;
    logic [IDX_W-1:0]        newest_reg, idx_reg, step_reg;
    logic [TIME_W-1:0]       last_reg;
    logic [SC_W-1:0]         scores_reg;
    logic [IF_W-1:0]         if_cnt_reg;

    logic              ev_ok_reg, ev_recent_reg;
    logic [IV_W-1:0]   ev_iv_reg;
    logic [IF_W-1:0]   ev_ifc_reg;
    logic [LSUM_W-1:0] lsum_reg [INTERFACES];
    logic [RSUM_W-1:0] rsum_reg [INTERFACES];

    logic        out_valid_reg, out_updated_reg, out_changed_reg, out_last_reg;
    logic [1:0]  out_index_reg;
    logic [7:0]  out_score_reg;
    logic [17:0] out_obs_reg;

    logic [NB_W-1:0]  nb_idx;
    logic             nbr_we;
    logic [NB_W-1:0]  nbr_waddr, nbr_raddr;
    logic [NBR_W-1:0] nbr_wdata, nbr_rdata;
    logic             obs_we;
    logic [OA_W-1:0]  obs_addr;
    obs_entry_t       obs_wdata, obs_rdata;

    logic [IDX_W-1:0]  newest_inc, idx_dec;
    logic [31:0]       interval;
    logic              future, fresh, recent, ifc_ok;
    logic [TIME_W-1:0] age;
    logic              skip;
    logic              load;
    logic              sc_go, sc_done;
    score_res_t        sc_res;
    logic [REC_W-1:0]  rec_add;
    logic              in_acc;

    assign nb_idx     = NB_W'(slot_reg);
    assign newest_inc = (newest_reg == IDX_W'(OBSERVATIONS - 1)) ? '0 : newest_reg + 1'b1;
    assign idx_dec    = (idx_reg == '0) ? IDX_W'(OBSERVATIONS - 1) : idx_reg - 1'b1;
    assign obs_addr   = obs_base_reg + OA_W'(idx_reg);
    assign in_acc     = req.valid && req.ready;

    assign interval = obs_rdata.range_end - obs_rdata.range_start;
    assign future   = obs_rdata.obs_time > now_reg;
    assign age      = now_reg - obs_rdata.obs_time;
    assign fresh    = future || (age <= TIME_W'(age_reg));
    assign recent   = future || (age <= TIME_W'(RECENT_AGE));
    assign ifc_ok   = (32'(obs_rdata.iface) < INTERFACES) && (obs_rdata.iface < 8'd4)
                      && up_mask_reg[obs_rdata.iface[1:0]];
    assign skip     = (last_reg != '0)
                      && ((now_reg < last_reg) || ((now_reg - last_reg) < TIME_W'(gap_reg)));
    assign rec_add  = (32'(ev_iv_reg) > RECENT_CAP) ? REC_W'(RECENT_CAP) : REC_W'(ev_iv_reg);
    assign load     = ((state_reg == S_EMIT) || (state_reg == S_SKIP))
                      && (!out_valid_reg || rsp.ready);
    assign sc_go    = (state_reg == S_SGO);

    assign nbr_we    = (state_reg == S_CLR) || (state_reg == S_WB);
    assign nbr_waddr = (state_reg == S_CLR) ? clr_cnt_reg : nb_idx;
    assign nbr_wdata = (state_reg == S_CLR) ? '0
                       : {mask_reg, newest_reg, last_reg, scores_reg};
    assign nbr_raddr = nb_idx;
    assign obs_we    = (state_reg == S_WR);
    assign obs_wdata = '{range_start: s1_reg, range_end: s2_reg,
                         obs_time: now_reg, iface: ifc_reg};

    nls_ram #(.WIDTH(NBR_W), .DEPTH(NEIGHBOURS), .AW(NB_W)) u_nbr_mem
    (
        .clk   (clk),
        .we    (nbr_we),
        .waddr (nbr_waddr),
        .wdata (nbr_wdata),
        .raddr (nbr_raddr),
        .rdata (nbr_rdata)
    );

    nls_ram #(.WIDTH(OBS_W), .DEPTH(NEIGHBOURS * OBSERVATIONS), .AW(OA_W)) u_obs_mem
    (
        .clk   (clk),
        .we    (obs_we),
        .waddr (obs_addr),
        .wdata (obs_wdata),
        .raddr (obs_addr),
        .rdata (obs_rdata)
    );

    nls_score #(.LSUM_W(LSUM_W), .RSUM_W(RSUM_W)) u_score
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sc_go),
        .lsum  (lsum_reg[if_cnt_reg]),
        .rsum  (rsum_reg[if_cnt_reg]),
        .done  (sc_done),
        .res   (sc_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == NB_W'(NEIGHBOURS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (32'(slot_reg) < NEIGHBOURS)
                begin
                    state_next = S_NRD;
                end
            end
            S_NRD: state_next = S_NLD;
            S_NLD: state_next = (op_reg == OP_OBSERVE) ? S_WRD : S_CHK;
            S_WRD: state_next = mask_reg[idx_reg] ? S_WCK : S_WR;
            S_WCK:
            begin
                if ((obs_rdata.range_end < s1_reg - 32'd1) || (obs_rdata.iface == ifc_reg)
                    || (step_reg == IDX_W'(OBSERVATIONS - 1)))
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_WR:   state_next = S_CHK;
            S_CHK:  state_next = skip ? S_SKIP : S_SRD;
            S_SRD:  state_next = S_SEV;
            S_SEV:  state_next = S_SADD;
            S_SADD: state_next = (idx_reg == IDX_W'(OBSERVATIONS - 1)) ? S_SGO : S_SRD;
            S_SGO:  state_next = S_SWT;
            S_SWT:
            begin
                if (sc_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    state_next = (if_cnt_reg == IF_W'(INTERFACES - 1)) ? S_WB : S_SGO;
                end
            end
            S_SKIP:
            begin
                if (load)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            up_mask_reg   <= '0;
            gap_reg       <= 16'(GAP_RESET);
            age_reg       <= 20'(AGE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_UP_MASK: up_mask_reg <= cfg.data[3:0];
                    CFG_MIN_GAP: gap_reg     <= cfg.data[15:0];
                    CFG_MAX_AGE: age_reg     <= cfg.data;
                    default:     ;
                endcase
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_reg   <= req.op;
                    slot_reg <= req.neighbour_slot;
                    s1_reg   <= req.range_start;
                    s2_reg   <= req.range_end;
                    ifc_reg  <= req.heard_iface;
                    now_reg  <= req.now_ms;
                end
            end
            S_MOD:
            begin
                if (32'(slot_reg) >= NEIGHBOURS)
                begin
                    slot_reg <= slot_reg - 7'(NEIGHBOURS);
                end
                obs_base_reg <= OA_W'(32'(nb_idx) * OBSERVATIONS);
            end
            S_NLD:
            begin
                {mask_reg, newest_reg, last_reg, scores_reg} <= nbr_rdata;
                idx_reg  <= nbr_rdata[SC_W + TIME_W +: IDX_W];
                step_reg <= '0;
            end
            S_WRD:
            begin
                if (!mask_reg[idx_reg])
                begin
                    idx_reg <= newest_inc;
                end
            end
            S_WCK:
            begin
                if (obs_rdata.range_end < s1_reg - 32'd1)
                begin
                    idx_reg <= newest_inc;
                end
                else if (obs_rdata.iface == ifc_reg)
                begin
                    s1_reg <= obs_rdata.range_start;
                end
                else if (step_reg == IDX_W'(OBSERVATIONS - 1))
                begin
                    idx_reg <= newest_inc;
                end
                else
                begin
                    idx_reg  <= idx_dec;
                    step_reg <= step_reg + 1'b1;
                end
            end
            S_WR:
            begin
                mask_reg[idx_reg] <= 1'b1;
                newest_reg        <= idx_reg;
                last_reg          <= '0;
            end
            S_CHK:
            begin
                if (!skip)
                begin
                    last_reg <= now_reg;
                    idx_reg  <= '0;
                    for (int j = 0; j < INTERFACES; j++)
                    begin
                        lsum_reg[j] <= '0;
                        rsum_reg[j] <= '0;
                    end
                end
            end
            S_SEV:
            begin
                ev_ok_reg     <= mask_reg[idx_reg] && ifc_ok && (interval < MAX_INTERVAL)
                                 && fresh;
                ev_recent_reg <= recent;
                ev_iv_reg     <= interval[IV_W-1:0];
                ev_ifc_reg    <= IF_W'(obs_rdata.iface);
            end
            S_SADD:
            begin
                for (int j = 0; j < INTERFACES; j++)
                begin
                    if (ev_ok_reg && (ev_ifc_reg == IF_W'(j)))
                    begin
                        lsum_reg[j] <= lsum_reg[j] + LSUM_W'(ev_iv_reg);
                        if (ev_recent_reg)
                        begin
                            rsum_reg[j] <= rsum_reg[j] + RSUM_W'(rec_add);
                        end
                    end
                end
                idx_reg    <= idx_reg + 1'b1;
                if_cnt_reg <= '0;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    scores_reg[8 * if_cnt_reg +: 8] <= sc_res.score;
                    if_cnt_reg <= if_cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase

        if (load)
        begin
            if (state_reg == S_EMIT)
            begin
                out_updated_reg <= 1'b1;
                out_index_reg   <= 2'(if_cnt_reg);
                out_score_reg   <= sc_res.score;
                out_changed_reg <= scores_reg[8 * if_cnt_reg +: 8] != sc_res.score;
                out_obs_reg     <= sc_res.observed;
                out_last_reg    <= (if_cnt_reg == IF_W'(INTERFACES - 1));
            end
            else
            begin
                out_updated_reg <= 1'b0;
                out_index_reg   <= '0;
                out_score_reg   <= '0;
                out_changed_reg <= 1'b0;
                out_obs_reg     <= '0;
                out_last_reg    <= 1'b1;
            end
        end
    end

    assign cfg.ready           = 1'b1;
    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.updated         = out_updated_reg;
    assign rsp.interface_index = out_index_reg;
    assign rsp.score           = out_score_reg;
    assign rsp.score_changed   = out_changed_reg;
    assign rsp.observed_ms     = out_obs_reg;
    assign rsp.last            = out_last_reg;

endmodule

### sim/neighbour_link_scoring_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_link_scoring_tb_if
// scoreboard types used by the neighbour link scoring testbench
// ----------------------------------------------------------------------------
// the block's own channel interfaces are in rtl/core/nls_if.sv; this file
// holds the scoreboard types shared by the testbench
// ----------------------------------------------------------------------------
package nls_tb_pkg;

    typedef struct packed
    {
        logic        updated;
        logic [1:0]  interface_index;
        logic [7:0]  score;
        logic        score_changed;
        logic [17:0] observed_ms;
        logic        last;
    } score_rec_t;

endpackage

### sim/neighbour_link_scoring_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_link_scoring_top_tb
// self-checking bench for the neighbour link scoring block
// ----------------------------------------------------------------------------
// drives observe and tick requests with random idling on both channels,
// predicts the score results of each request from a behavioral copy of the
// observation rings and compares every result field against it
// ----------------------------------------------------------------------------
module neighbour_link_scoring_top_tb;
    import nls_pkg::*;
    import nls_tb_pkg::*;

    localparam int OBS = 8;
    localparam int IFS = 4;
    localparam int NBS = 128;
    localparam int WATCH_LIMIT = 200000;

    class link_score_board;
        logic [3:0]  up_mask;
        logic [15:0] min_gap;
        logic [19:0] max_age;
        bit          ent_valid [NBS*OBS];
        logic [31:0] ent_start [NBS*OBS];
        logic [31:0] ent_end [NBS*OBS];
        logic [62:0] ent_time [NBS*OBS];
        logic [7:0]  ent_iface [NBS*OBS];
        int unsigned newest [NBS];
        logic [62:0] last_upd [NBS];
        logic [7:0]  stored [NBS*IFS];
        score_rec_t  pending [$];
        int          errors;

        function new();
            up_mask = 4'd0;
            min_gap = 16'(GAP_RESET);
            max_age = 20'(AGE_RESET);
            errors = 0;
            foreach (ent_valid[i]) ent_valid[i] = 0;
            foreach (newest[i]) newest[i] = 0;
            foreach (last_upd[i]) last_upd[i] = '0;
            foreach (stored[i]) stored[i] = '0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [19:0] val);
            case (idx)
                CFG_UP_MASK: up_mask = val[3:0];
                CFG_MIN_GAP: min_gap = val[15:0];
                CFG_MAX_AGE: max_age = val;
                default: ;
            endcase
        endfunction

        function void note_request(op_t op, logic [6:0] nb, logic [31:0] s1,
                                   logic [31:0] s2, logic [7:0] ifc, logic [62:0] now);
            int unsigned base, idx;
            bit merged;
            longint unsigned lsum [IFS];
            longint unsigned rsum [IFS];
            longint unsigned age, l, r;
            logic [31:0] iv;
            int unsigned a, b, sc, e;
            score_rec_t rec;
            base = nb * OBS;
            if (op == OP_OBSERVE)
            begin
                idx = newest[nb];
                merged = 0;
                for (int s = 0; s < OBS; s++)
                begin
                    e = base + idx;
                    if (!ent_valid[e] || ent_end[e] < s1 - 32'd1) break;
                    if (ent_iface[e] == ifc)
                    begin
                        s1 = ent_start[e];
                        merged = 1;
                        break;
                    end
                    idx = (idx == 0) ? OBS - 1 : idx - 1;
                end
                if (!merged) idx = (newest[nb] + 1) % OBS;
                ent_start[base+idx] = s1;
                ent_end[base+idx] = s2;
                ent_iface[base+idx] = ifc;
                ent_time[base+idx] = now;
                ent_valid[base+idx] = 1;
                newest[nb] = idx;
                last_upd[nb] = '0;
            end
            if (last_upd[nb] != 0 &&
                (now < last_upd[nb] || now - last_upd[nb] < {47'd0, min_gap}))
            begin
                rec = '{1'b0, 2'd0, 8'd0, 1'b0, 18'd0, 1'b1};
                pending.push_back(rec);
                return;
            end
            last_upd[nb] = now;
            for (int i = 0; i < IFS; i++)
            begin
                lsum[i] = 0;
                rsum[i] = 0;
            end
            for (int i = 0; i < OBS; i++)
            begin
                e = base + i;
                if (!ent_valid[e] || ent_iface[e] >= IFS || !up_mask[ent_iface[e]]) continue;
                iv = ent_end[e] - ent_start[e];
                age = (ent_time[e] > now) ? 0 : now - ent_time[e];
                if (iv >= MAX_INTERVAL || age > max_age) continue;
                lsum[ent_iface[e]] += iv;
                if (age <= RECENT_AGE)
                    rsum[ent_iface[e]] += (iv > RECENT_CAP) ? RECENT_CAP : iv;
            end
            for (int i = 0; i < IFS; i++)
            begin
                l = (lsum[i] > LONG_CAP) ? LONG_CAP : lsum[i];
                r = (rsum[i] > RECENT_CAP) ? RECENT_CAP : rsum[i];
                if (l == 0) sc = 0;
                else
                begin
                    a = 32'(l / A_DIV);
                    b = 32'(r / B_DIV);
                    sc = (b < 1) ? a / 2 : a + b;
                    if (sc < 1) sc = 1;
                    if (sc > SCORE_MAX) sc = SCORE_MAX;
                end
                rec.updated = 1'b1;
                rec.interface_index = 2'(i);
                rec.score = 8'(sc);
                rec.score_changed = (stored[nb*IFS+i] != sc);
                rec.observed_ms = 18'(l);
                rec.last = (i == IFS - 1);
                stored[nb*IFS+i] = 8'(sc);
                pending.push_back(rec);
            end
        endfunction

        function void check_result(score_rec_t got);
            score_rec_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    always #5 clk = ~clk;

    nls_cfg_if cfg ();
    nls_in_if req ();
    nls_out_if rsp ();

    neighbour_link_scoring_top dut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .req(req), .rsp(rsp));

    link_score_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;
    int watch = 0;
    logic [62:0] clock_ms = 1000;

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            board.note_request(op_t'(req.op), req.neighbour_slot, req.range_start,
                               req.range_end, req.heard_iface, req.now_ms);
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result('{rsp.updated, rsp.interface_index, rsp.score,
                                 rsp.score_changed, rsp.observed_ms, rsp.last});
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            watch <= 0;
        else
            watch <= watch + 1;
    end

    always @(posedge clk)
    begin
        if (watch >= WATCH_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
        if (!rst_n) rsp.ready <= 0;
        else if (hold_off) rsp.ready <= 0;
        else rsp.ready <= ($urandom_range(99) >= recv_stall);

    task automatic write_reg(cfg_index_t idx, logic [19:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        board.set_reg(idx, val);
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    // leaves valid high after the accepting edge; the next idle cycle or
    // the caller drops it
    task automatic send(op_t op, logic [6:0] nb, logic [31:0] s1, logic [31:0] s2,
                        logic [7:0] ifc, logic [62:0] now);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.op <= op;
        req.neighbour_slot <= nb;
        req.range_start <= s1;
        req.range_end <= s2;
        req.heard_iface <= ifc;
        req.now_ms <= now;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // ranges half the time anchored at the running clock, mostly on a few neighbours, so merges and scores happen
    task automatic random_request();
        logic [6:0] nb;
        logic [31:0] s1, len;
        logic [7:0] ifc;
        int unsigned k;
        k = $urandom_range(99);
        nb = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(5));
        clock_ms += $urandom_range(3000);
        ifc = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        len = ($urandom_range(19) == 0) ? $urandom : $urandom_range(8000);
        s1 = ($urandom_range(1) == 0) ? 32'(clock_ms) : $urandom;
        if (k < 75)
            send(OP_OBSERVE, nb, s1, s1 + len, ifc, clock_ms);
        else if (k < 95)
            send(OP_TICK, nb, $urandom, $urandom, 8'($urandom), clock_ms);
        else
            send(op_t'($urandom_range(1)), nb, $urandom, $urandom, 8'($urandom),
                 63'({$urandom, $urandom}));
    endtask

    initial
    begin
        cfg.valid = 0;
        cfg.index = CFG_UP_MASK;
        cfg.data = '0;
        req.valid = 0;
        req.op = OP_TICK;
        req.neighbour_slot = '0;
        req.range_start = '0;
        req.range_end = '0;
        req.heard_iface = '0;
        req.now_ms = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        write_reg(CFG_UP_MASK, 20'hF);
        send(OP_TICK, 7'd0, 32'd0, 32'd0, 8'd0, 63'd0);
        send(OP_OBSERVE, 7'd0, 32'd100, 32'd2100, 8'd0, 63'd1000);
        send(OP_OBSERVE, 7'd0, 32'd2101, 32'd4000, 8'd0, 63'd1100);
        send(OP_OBSERVE, 7'd0, 32'd3000, 32'd9000, 8'd1, 63'd1200);
        send(OP_OBSERVE, 7'd0, 32'd4001, 32'd5000, 8'd0, 63'd1300);
        send(OP_TICK, 7'd0, 32'd0, 32'd0, 8'd0, 63'd1400);
        send(OP_TICK, 7'd0, 32'd0, 32'd0, 8'd0, 63'd2000);
        send(OP_TICK, 7'd0, 32'd0, 32'd0, 8'd0, 63'd500);
        send(OP_OBSERVE, 7'd127, 32'hFFFF_FFFF, 32'h0000_1000, 8'hFF, 63'h7FFF_FFFF_FFFF_FFFF);
        send(OP_OBSERVE, 7'd127, 32'd0, 32'hFFFF_FFFF, 8'd3, 63'h7FFF_FFFF_FFFF_FFF0);
        send(OP_OBSERVE, 7'd127, 32'd5, 32'd3600004, 8'd2, 63'h7FFF_FFFF_FFFF_FFF8);
        send(OP_OBSERVE, 7'd127, 32'd5, 32'd3600003, 8'd2, 63'h7FFF_FFFF_FFFF_FFF9);
        send(OP_OBSERVE, 7'd1, 32'd0, 32'd200000, 8'd3, 63'd30000);
        send(OP_OBSERVE, 7'd1, 32'd0, 32'd5, 8'd2, 63'd40000);
        send(OP_TICK, 7'd1, 32'd0, 32'd0, 8'd0, 63'd60001);
        for (int i = 0; i < 9; i++)
            send(OP_OBSERVE, 7'd2, 32'(i * 50), 32'(i * 50 + 10), 8'(i % 5),
                 63'(70000 + i));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_UP_MASK, 20'h5);
                    write_reg(CFG_MIN_GAP, 20'd0);
                    write_reg(CFG_MAX_AGE, 20'hFFFFF);
                    send_idle = 0; recv_stall = 0;
                end
                1:
                begin
                    write_reg(CFG_UP_MASK, 20'hF);
                    write_reg(CFG_MIN_GAP, 20'hFFFF);
                    write_reg(CFG_MAX_AGE, 20'd0);
                    send_idle = 52; recv_stall = 0;
                end
                2:
                begin
                    write_reg(CFG_UP_MASK, 20'hA);
                    write_reg(CFG_MIN_GAP, 20'd1500);
                    write_reg(CFG_MAX_AGE, 20'd8000);
                    send_idle = 0; recv_stall = 52;
                end
                default:
                begin
                    write_reg(CFG_UP_MASK, 20'hF);
                    write_reg(CFG_MIN_GAP, 20'(GAP_RESET));
                    write_reg(CFG_MAX_AGE, 20'(AGE_RESET));
                    send_idle = 25; recv_stall = 25;
                end
            endcase
            if (ph == 0)
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int n = 0; n < 120; n++)
            begin
                random_request();
                if (n == 60)
                begin
                    req.valid <= 0;
                    while (board.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
